// ===== rtl/core/fpe_pkg.sv =====
package fpe_pkg;

	localparam int MAX_FERNS_DEF  = 16;
	localparam int COMP_BITS_DEF  = 10;
	localparam int COUNT_BITS_DEF = 16;

	localparam int REQ_W  = 2;
	localparam int FERN_W = 4;
	localparam int LEAF_W = 10;
	localparam int CFG_W  = 5;
	localparam int FRAC_W = 16;
	localparam int VOTE_W = 20;

	localparam logic [CFG_W-1:0] FERN_COUNT_RST = 5'd10;

	localparam logic [REQ_W-1:0] REQ_TRAIN_POS = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TRAIN_NEG = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLASSIFY  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clr_step;
		logic rd;
		logic cnt_wr;
		logic div_go_post;
		logic post_wr;
		logic vote_add;
		logic div_go_mean;
		logic res_fire;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic is_train;
		logic is_classify;
		logic is_last;
	} sts_t;

	// quotients above 16 bits clamp to the largest fraction
	function automatic logic [FRAC_W-1:0] sat_frac(input logic [VOTE_W-1:0] q);
		sat_frac = (|q[VOTE_W-1:FRAC_W]) ? {FRAC_W{1'b1}} : q[FRAC_W-1:0];
	endfunction

endpackage

// ===== rtl/core/fpe_div.sv =====
module fpe_div
	import fpe_pkg::*;
#(
	parameter int DW  = 32,
	parameter int DVW = 17,
	parameter int QW  = VOTE_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic [DW-1:0]  dividend,
	input  logic [DVW-1:0] divisor,
	output logic           done,
	output logic [QW-1:0]  quot
);

	localparam int CW = (QW > 1) ? $clog2(QW) : 1;
	localparam logic [CW-1:0] CNT_TOP = CW'(QW - 1);

	logic [DVW-1:0] rem_q;
	logic [DVW-1:0] dvs_q;
	logic [QW-1:0]  sh_q;
	logic [CW-1:0]  cnt_q;
	logic           run_q;
	logic           done_q;

	logic [DVW:0] trial;
	logic [DVW:0] diff;
	logic         fits;

	// restoring step: one quotient bit per cycle, low dividend bits shift out as
	// quotient bits shift in
	assign trial = {rem_q, sh_q[QW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_TOP;
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= DVW'(dividend >> QW);
			sh_q  <= dividend[QW-1:0];
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? diff[DVW-1:0] : trial[DVW-1:0];
			sh_q  <= {sh_q[QW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = sh_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> !run_q)
		else $error("divider restarted while running");

endmodule

// ===== rtl/core/fpe_dpath.sv =====
module fpe_dpath
	import fpe_pkg::*;
#(
	parameter int MAX_FERNS  = MAX_FERNS_DEF,
	parameter int COMP_BITS  = COMP_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [FERN_W-1:0] fern_index,
	input  logic [LEAF_W-1:0] leaf_code,
	input  logic              last_fern,
	output logic              done,
	output logic [FRAC_W-1:0] mean_posterior
);

	localparam int FI_W  = (MAX_FERNS > 1) ? $clog2(MAX_FERNS) : 1;
	localparam int AW    = FI_W + COMP_BITS;
	localparam int DEPTH = MAX_FERNS * (1 << COMP_BITS);
	localparam int DW    = COUNT_BITS + FRAC_W;
	localparam int DVW   = COUNT_BITS + 1;
	localparam int NFI   = 1 << FERN_W;

	logic [FI_W-1:0] fern_tab [NFI];

	genvar g;
	generate
		for (g = 0; g < NFI; g++) begin : g_fern
			localparam int FM = g % MAX_FERNS;
			assign fern_tab[g] = FI_W'(FM);
		end
	endgenerate

	logic [COUNT_BITS-1:0] pos_mem  [DEPTH];
	logic [COUNT_BITS-1:0] neg_mem  [DEPTH];
	logic [FRAC_W-1:0]     post_mem [DEPTH];

	logic [REQ_W-1:0]      req_q;
	logic                  last_q;
	logic [AW-1:0]         addr_q;
	logic [AW-1:0]         clr_addr_q;
	logic [COUNT_BITS-1:0] pos_rd_q;
	logic [COUNT_BITS-1:0] neg_rd_q;
	logic [FRAC_W-1:0]     post_rd_q;
	logic [VOTE_W-1:0]     vote_q;
	logic [CFG_W-1:0]      fern_count_q;
	logic [FRAC_W-1:0]     mean_q;
	logic                  done_q;

	logic [AW-1:0]         wr_addr;
	logic [COUNT_BITS-1:0] pos_new;
	logic [COUNT_BITS-1:0] neg_new;
	logic [COUNT_BITS-1:0] pos_wd;
	logic [COUNT_BITS-1:0] neg_wd;
	logic [FRAC_W-1:0]     post_wd;
	logic [VOTE_W:0]       vote_sum;
	logic [CFG_W-1:0]      fc_eff;
	logic                  div_go;
	logic [DW-1:0]         dividend;
	logic [DVW-1:0]        divisor;
	logic                  div_done;
	logic [VOTE_W-1:0]     quot;

	assign cfg_ready = 1'b1;

	// bump the selected counter, hold it at full scale
	assign pos_new = (req_q == REQ_TRAIN_POS && !(&pos_rd_q)) ?
		pos_rd_q + COUNT_BITS'(1) : pos_rd_q;
	assign neg_new = (req_q == REQ_TRAIN_NEG && !(&neg_rd_q)) ?
		neg_rd_q + COUNT_BITS'(1) : neg_rd_q;

	assign wr_addr = cmd.clr_step ? clr_addr_q : addr_q;
	assign pos_wd  = cmd.clr_step ? '0 : pos_new;
	assign neg_wd  = cmd.clr_step ? '0 : neg_new;
	assign post_wd = cmd.clr_step ? '0 : sat_frac(quot);

	assign fc_eff   = (fern_count_q == '0) ? CFG_W'(1) : fern_count_q;
	assign div_go   = cmd.div_go_post | cmd.div_go_mean;
	assign dividend = cmd.div_go_mean ? DW'(vote_q) : {pos_new, FRAC_W'(0)};
	assign divisor  = cmd.div_go_mean ? DVW'(fc_eff) : DVW'(pos_new) + DVW'(neg_new);

	assign vote_sum = {1'b0, vote_q} + (VOTE_W + 1)'(post_rd_q);

	always_ff @(posedge clk) begin
		if (cmd.clr_step || cmd.cnt_wr) begin
			pos_mem[wr_addr] <= pos_wd;
			neg_mem[wr_addr] <= neg_wd;
		end
		if (cmd.rd) begin
			pos_rd_q <= pos_mem[addr_q];
			neg_rd_q <= neg_mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step || cmd.post_wr) begin
			post_mem[wr_addr] <= post_wd;
		end
		if (cmd.rd) begin
			post_rd_q <= post_mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			last_q <= last_fern;
			addr_q <= {fern_tab[fern_index], COMP_BITS'(leaf_code)};
		end
		if (cmd.res_fire) begin
			mean_q <= sat_frac(quot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			vote_q       <= '0;
			fern_count_q <= FERN_COUNT_RST;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.res_fire;
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cfg_valid && cfg_ready) begin
				fern_count_q <= cfg_data;
			end
			if (cmd.res_fire) begin
				vote_q <= '0;
			end else if (cmd.vote_add) begin
				vote_q <= vote_sum[VOTE_W] ? {VOTE_W{1'b1}} : vote_sum[VOTE_W-1:0];
			end
		end
	end

	fpe_div #(
		.DW  (DW),
		.DVW (DVW),
		.QW  (VOTE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quot     (quot)
	);

	assign sts.clr_last    = (clr_addr_q == AW'(DEPTH - 1));
	assign sts.div_done    = div_done;
	assign sts.is_train    = (req_q == REQ_TRAIN_POS) || (req_q == REQ_TRAIN_NEG);
	assign sts.is_classify = (req_q == REQ_CLASSIFY);
	assign sts.is_last     = last_q;

	assign done           = done_q;
	assign mean_posterior = mean_q;

	a_vote_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.vote_add && !cmd.res_fire) |=> (vote_q >= $past(vote_q)))
		else $error("vote wrapped instead of saturating");

endmodule

// ===== rtl/core/fpe_ctrl.sv =====
module fpe_ctrl
	import fpe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_POST_WAIT,
		ST_POST_WRITE,
		ST_VOTE,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_MEAN_OUT
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;
	logic   busy_q;

	// commands are registered: each set here applies in the state being entered
	always_ff @(posedge clk or negedge arst_n) begin
		cmd_t cmd_n;
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cmd_q   <= '{clr_step: 1'b1, default: 1'b0};
			busy_q  <= 1'b1;
		end else begin
			cmd_n = '0;
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q    <= ST_IDLE;
						cmd_n.load = 1'b1;
						busy_q     <= 1'b0;
					end else begin
						cmd_n.clr_step = 1'b1;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q  <= ST_READ;
						cmd_n.rd = 1'b1;
						busy_q   <= 1'b1;
					end else begin
						cmd_n.load = 1'b1;
					end
				end
				ST_READ: begin
					if (sts.is_train) begin
						state_q           <= ST_UPDATE;
						cmd_n.cnt_wr      = 1'b1;
						cmd_n.div_go_post = 1'b1;
					end else if (sts.is_classify) begin
						state_q        <= ST_VOTE;
						cmd_n.vote_add = 1'b1;
					end else begin
						// unused request code: drop the item
						state_q    <= ST_IDLE;
						cmd_n.load = 1'b1;
						busy_q     <= 1'b0;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_POST_WAIT;
				end
				ST_POST_WAIT: begin
					if (sts.div_done) begin
						state_q       <= ST_POST_WRITE;
						cmd_n.post_wr = 1'b1;
					end
				end
				ST_POST_WRITE: begin
					state_q    <= ST_IDLE;
					cmd_n.load = 1'b1;
					busy_q     <= 1'b0;
				end
				ST_VOTE: begin
					if (sts.is_last) begin
						state_q           <= ST_MEAN_GO;
						cmd_n.div_go_mean = 1'b1;
					end else begin
						state_q    <= ST_IDLE;
						cmd_n.load = 1'b1;
						busy_q     <= 1'b0;
					end
				end
				ST_MEAN_GO: begin
					state_q <= ST_MEAN_WAIT;
				end
				ST_MEAN_WAIT: begin
					if (sts.div_done) begin
						state_q        <= ST_MEAN_OUT;
						cmd_n.res_fire = 1'b1;
					end
				end
				ST_MEAN_OUT: begin
					state_q    <= ST_IDLE;
					cmd_n.load = 1'b1;
					busy_q     <= 1'b0;
				end
				default: begin
					state_q    <= ST_IDLE;
					cmd_n.load = 1'b1;
					busy_q     <= 1'b0;
				end
			endcase
			cmd_q <= cmd_n;
		end
	end

	assign busy = busy_q;
	assign cmd  = cmd_q;

	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (busy_q == (state_q != ST_IDLE)))
		else $error("busy out of step with controller state");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_POST_WAIT || state_q == ST_MEAN_WAIT))
		else $error("divider finished outside a wait state");

	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> cmd_q.rd)
		else $error("accepted item not followed by table read");

endmodule

// ===== rtl/core/fern_posterior_engine_core.sv =====
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+--------------------------------------
// request   | in        | start, busy          | req_type, fern_index, leaf_code, last_fern
// result    | out       | done (one-cycle)     | mean_posterior
// config    | in        | cfg_valid, cfg_ready | cfg_data (fern_count)
//
// An item is taken when start is high and busy is low. A training item updates its
// counters, then waits on the shared restoring divider to write its posterior; a
// classify item adds its posterior to the vote, and one marked last then waits on the
// divider for the mean. After reset the tables are swept clear, one entry a cycle, all
// MAX_FERNS * 2^COMP_BITS entries (16384 at the defaults), with busy high; cfg_ready is
// always high. done lasts one cycle and cannot be held off by the receiver.
module fern_posterior_engine_core
	import fpe_pkg::*;
#(
	parameter int MAX_FERNS  = MAX_FERNS_DEF,
	parameter int COMP_BITS  = COMP_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [FERN_W-1:0] fern_index,
	input  logic [LEAF_W-1:0] leaf_code,
	input  logic              last_fern,
	output logic              done,
	output logic [FRAC_W-1:0] mean_posterior,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data
);

	cmd_t cmd;
	sts_t sts;

	fpe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	fpe_dpath #(
		.MAX_FERNS  (MAX_FERNS),
		.COMP_BITS  (COMP_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.req_type       (req_type),
		.fern_index     (fern_index),
		.leaf_code      (leaf_code),
		.last_fern      (last_fern),
		.done           (done),
		.mean_posterior (mean_posterior)
	);

endmodule
